// ===== hdl/alle_pkg.sv =====
package alle_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam int VAL_W = 32;
  localparam int FLD_W = 4;

  typedef enum logic [1:0] {
    OP_FIND       = 2'd0,
    OP_INS_AFTER  = 2'd1,
    OP_INS_BEFORE = 2'd2,
    OP_DELETE     = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e_t;

  typedef struct packed {
    op_e_t                    op;
    logic signed [VAL_W-1:0]  key;
    logic signed [VAL_W-1:0]  new_value;
  } in_item_t;

  typedef struct packed {
    status_e_t          status;
    logic [FLD_W-1:0]   position;
    logic [FLD_W-1:0]   length;
  } out_item_t;

endpackage

// ===== hdl/array_linked_list_engine.sv =====
// channel | ports                        | handshake
// --------+------------------------------+--------------------------------------
// input   | start, busy, in_item         | beat taken when start & !busy
// result  | out_valid, out_item          | one-cycle strobe, cannot be stalled
//
// one operation runs from accept to result strobe as follows: the list
// walk reads one linked node per cycle (up to SLOTS-1 nodes) while the free-slot
// scan checks one used bit per cycle alongside it, then the commit state updates.
// busy stays high from the accept edge until the result strobe is driven.
// synchronous active-low reset empties the list; node values hold no reset.
// the receiver cannot stall, so the result register never waits.
module array_linked_list_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  alle_pkg::in_item_t  in_item,
  output logic                out_valid,
  output alle_pkg::out_item_t out_item
);
  import alle_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);
  localparam logic [IDX_W-1:0] HEAD = '0;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // list storage: value per slot, link per slot (slot 0 is the head sentinel)
  logic [VAL_W-1:0] node_value_r [SLOTS];
  logic [IDX_W-1:0] node_link_r  [SLOTS];
  logic [SLOTS-1:0] slot_used_r;
  logic [IDX_W-1:0] count_r;

  // latched operation
  op_e_t            op_r;
  logic [VAL_W-1:0] key_r;
  logic [VAL_W-1:0] nv_r;
  logic             empty_r;
  logic             full_r;

  // walk unit
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] prev_r, prev_nxt;
  logic [IDX_W-1:0] steps_r, steps_nxt;
  logic [IDX_W-1:0] hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_link_r, hit_link_nxt;
  logic             walk_done_r, walk_done_nxt;
  logic             found_r, found_nxt;

  // free-slot scan unit
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic [IDX_W-1:0] free_r, free_nxt;
  logic             scan_done_r, scan_done_nxt;

  // commit decode
  status_e_t        status_c;
  logic             do_ins;
  logic             do_del;
  logic [31:0]      pos32;

  logic accept;
  logic is_ins;
  logic head_empty;

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign is_ins     = (in_item.op == OP_INS_AFTER) || (in_item.op == OP_INS_BEFORE);
  assign head_empty = (node_link_r[HEAD] == HEAD);
  assign pos32      = 32'(steps_r) + 32'd1;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_WALK;
      S_WALK:   if (walk_done_r && scan_done_r) state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // walk and scan step, both advance one element per cycle
  always_comb begin
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    steps_nxt     = steps_r;
    hit_nxt       = hit_r;
    hit_link_nxt  = hit_link_r;
    walk_done_nxt = walk_done_r;
    found_nxt     = found_r;
    scan_nxt      = scan_r;
    free_nxt      = free_r;
    scan_done_nxt = scan_done_r;
    if (accept) begin
      cur_nxt       = node_link_r[HEAD];
      prev_nxt      = HEAD;
      steps_nxt     = '0;
      found_nxt     = 1'b0;
      // empty list or full insert: no walk needed
      walk_done_nxt = head_empty || (is_ins && (count_r >= LAST));
      scan_nxt      = IDX_W'(1);
      free_nxt      = '0;
      // only inserts that can succeed need a free slot
      scan_done_nxt = !is_ins || (count_r >= LAST);
    end else if (state_r == S_WALK) begin
      if (!walk_done_r) begin
        priority if (cur_r == HEAD || steps_r == LAST) begin
          walk_done_nxt = 1'b1;
        end else if (node_value_r[cur_r] == key_r) begin
          walk_done_nxt = 1'b1;
          found_nxt     = 1'b1;
          hit_nxt       = cur_r;
          hit_link_nxt  = node_link_r[cur_r];
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = node_link_r[cur_r];
          steps_nxt = steps_r + IDX_W'(1);
        end
      end
      if (!scan_done_r) begin
        priority if (!slot_used_r[scan_r]) begin
          free_nxt      = scan_r;
          scan_done_nxt = 1'b1;
        end else if (scan_r == LAST) begin
          scan_done_nxt = 1'b1;
        end else begin
          scan_nxt = scan_r + IDX_W'(1);
        end
      end
    end
  end

  // result and update decision in the commit cycle
  always_comb begin
    status_c = ST_OK;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    unique case (op_r)
      OP_FIND: begin
        priority if (empty_r) status_c = ST_EMPTY;
        else if (!found_r)    status_c = ST_NOT_FOUND;
        else                  status_c = ST_OK;
      end
      OP_INS_AFTER, OP_INS_BEFORE: begin
        priority if (full_r)             status_c = ST_FULL;
        else if (!empty_r && !found_r)   status_c = ST_NOT_FOUND;
        else if (free_r == HEAD)         status_c = ST_FULL;
        else                             do_ins   = 1'b1;
      end
      OP_DELETE: begin
        priority if (empty_r) status_c = ST_EMPTY;
        else if (!found_r)    status_c = ST_NOT_FOUND;
        else                  do_del   = 1'b1;
      end
      default: status_c = ST_OK;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      walk_done_r <= 1'b1;
      scan_done_r <= 1'b1;
      found_r     <= 1'b0;
      out_valid   <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      walk_done_r <= walk_done_nxt;
      scan_done_r <= scan_done_nxt;
      found_r     <= found_nxt;
      out_valid   <= (state_r == S_COMMIT);
      if (state_r == S_COMMIT) begin
        if (do_ins) count_r <= count_r + IDX_W'(1);
        else if (do_del && count_r != '0) count_r <= count_r - IDX_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    steps_r    <= steps_nxt;
    hit_r      <= hit_nxt;
    hit_link_r <= hit_link_nxt;
    scan_r     <= scan_nxt;
    free_r     <= free_nxt;
    if (accept) begin
      op_r    <= in_item.op;
      key_r   <= in_item.key;
      nv_r    <= in_item.new_value;
      empty_r <= head_empty;
      full_r  <= (count_r >= LAST);
    end
    if (state_r == S_COMMIT) begin
      out_item.status   <= status_c;
      out_item.position <= (op_r == OP_FIND && status_c == ST_OK) ? pos32[FLD_W-1:0]
                                                                   : '0;
      // length after the update
      if (do_ins)
        out_item.length <= FLD_W'(32'(count_r) + 32'd1);
      else if (do_del && count_r != '0)
        out_item.length <= FLD_W'(32'(count_r) - 32'd1);
      else
        out_item.length <= FLD_W'(32'(count_r));
    end
  end

  // links and used bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) node_link_r[i] <= '0;
      slot_used_r <= '0;
    end else if (state_r == S_COMMIT) begin
      if (do_ins) begin
        slot_used_r[free_r] <= 1'b1;
        priority if (empty_r) begin
          node_link_r[free_r] <= HEAD;
          node_link_r[HEAD]   <= free_r;
        end else if (op_r == OP_INS_AFTER) begin
          node_link_r[free_r] <= hit_link_r;
          node_link_r[hit_r]  <= free_r;
        end else begin
          node_link_r[free_r] <= hit_r;
          node_link_r[prev_r] <= free_r;
        end
      end
      if (do_del) begin
        node_link_r[prev_r] <= hit_link_r;
        node_link_r[hit_r]  <= HEAD;
        slot_used_r[hit_r]  <= 1'b0;
      end
    end
  end

  // node values, undefined until written
  always_ff @(posedge clk) begin
    if (state_r == S_COMMIT && do_ins) node_value_r[free_r] <= nv_r;
  end

endmodule
